// ===== rtl/core/eth_ipv4_udp_header_extract_defines.svh =====
// Assertion macros shared by the header extractor RTL.
// No dependencies; the including module must have clk and arst_n in scope.
`ifndef ETH_IPV4_UDP_HEADER_EXTRACT_DEFINES_SVH
`define ETH_IPV4_UDP_HEADER_EXTRACT_DEFINES_SVH

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define EIUH_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Whenever the antecedent holds, the consequent must hold in the next cycle.
`define EIUH_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/eiuh_pkg.sv =====
// Types and constants of the Ethernet/IPv4/UDP header extractor.
// No dependencies; used by every module of the block.
package eiuh_pkg;

	localparam int MAX_FRAME_BYTES_DEF = 16383;

	localparam int OFS_ETHERTYPE_HI = 12;
	localparam int OFS_ETHERTYPE_LO = 13;
	localparam int IP_BASE          = 14;
	localparam int OFS_PROTOCOL     = 23;
	localparam int OFS_SRC_ADDR_FIRST = 26;
	localparam int OFS_SRC_ADDR_LAST  = 29;
	localparam int OFS_DST_ADDR_FIRST = 30;
	localparam int OFS_DST_ADDR_LAST  = 33;
	localparam int WORD_BYTES       = 4;
	localparam int UDP_HDR_BYTES    = 8;
	localparam int MIN_IP_END       = 34;

	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [7:0]  PROTO_UDP      = 8'd17;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_word_t;

	typedef struct packed {
		logic        accepted;
		logic [31:0] source_address;
		logic [31:0] dest_address;
		logic [15:0] source_port;
		logic [15:0] dest_udp;
	} out_word_t;

	typedef struct packed {
		logic full;
		logic not_empty;
	} q_status_t;

endpackage

// ===== rtl/core/eth_ipv4_udp_header_extract.sv =====
// Ethernet/IPv4/UDP header extractor, top level. Depends on eiuh_pkg, eiuh_front,
// eiuh_fifo, eiuh_back and the assertion macro header.
//
// Takes a frame one byte per cycle while byte_stall is low, from the destination MAC
// onward and, on the byte marked last, produces one result word: accepted is set for
// an IPv4 (ethertype 0x0800) UDP frame long enough to hold the IP header and the UDP
// header, with the addresses and ports captured; otherwise every field is zero.
// Results pass through a two-entry queue into the output register, so bytes keep
// flowing while the output is stalled until that queue fills; the sustained rate is
// one byte per cycle while the queue is not full. The byte counter saturates at
// MAX_FRAME_BYTES.
module eth_ipv4_udp_header_extract #(
	parameter int MAX_FRAME_BYTES = eiuh_pkg::MAX_FRAME_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_stall,
	input  eiuh_pkg::in_word_t  byte_word,
	output logic                result_valid,
	input  logic                result_stall,
	output eiuh_pkg::out_word_t result_word
);
	import eiuh_pkg::*;

	`include "eth_ipv4_udp_header_extract_defines.svh"

	logic      fire;
	logic      push;
	logic      pop;
	out_word_t entry;
	out_word_t head;
	q_status_t q_status;
	logic      fields_zero;

	assign byte_stall = q_status.full;
	assign fire       = byte_valid && !byte_stall;

	assign fields_zero = result_word.source_address == '0 &&
		result_word.dest_address == '0 && result_word.source_port == '0 &&
		result_word.dest_udp == '0;

	eiuh_front #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.fire  (fire),
		.word  (byte_word),
		.push  (push),
		.entry (entry)
	);

	eiuh_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_word(entry),
		.pop      (pop),
		.head     (head),
		.status   (q_status)
	);

	eiuh_back u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.status(q_status),
		.head  (head),
		.pop   (pop),
		.stall (result_stall),
		.valid (result_valid),
		.word  (result_word)
	);

	`EIUH_ASSERT_IMP(a_no_push_full, push, !q_status.full || pop, "result queue overflow")
	`EIUH_ASSERT_NEXT(a_pop_shows, pop, result_valid, "popped word not presented")
	`EIUH_ASSERT_IMP(a_reject_zero, result_valid && !result_word.accepted, fields_zero, "rejected frame carries data")

endmodule

// ===== rtl/core/eiuh_front.sv =====
// Front end: counts frame bytes, captures header fields and classifies the frame.
// Depends on eiuh_pkg. Pushes one entry per last byte into the result queue.
module eiuh_front #(
	parameter int MAX_FRAME_BYTES = eiuh_pkg::MAX_FRAME_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  eiuh_pkg::in_word_t  word,
	output logic                push,
	output eiuh_pkg::out_word_t entry
);
	import eiuh_pkg::*;

	localparam int IDX_W = $clog2(MAX_FRAME_BYTES + 1);
	localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_FRAME_BYTES);
	// Tests on the offset of the last byte rather than on the frame length.
	localparam logic [IDX_W-1:0] LAST_MIN = IDX_W'(MIN_IP_END - 1);
	localparam logic [IDX_W-1:0] NEED_BIAS = IDX_W'(IP_BASE + UDP_HDR_BYTES - 1);

	logic [IDX_W-1:0] idx_q;
	logic [15:0]      ether_q;
	logic [3:0]       hw_q;
	logic [7:0]       proto_q;
	logic [31:0]      src_addr_q;
	logic [31:0]      dst_addr_q;
	logic [15:0]      sport_q;
	logic [15:0]      dport_q;

	logic             counting;
	logic [15:0]      ether_d;
	logic [3:0]       hw_d;
	logic [7:0]       proto_d;
	logic [31:0]      src_addr_d;
	logic [31:0]      dst_addr_d;
	logic [15:0]      sport_d;
	logic [15:0]      dport_d;
	logic [IDX_W-1:0] hw_bytes;
	logic [IDX_W-1:0] port_base;
	logic             ok;

	always_comb begin
		counting   = idx_q < IDX_MAX;
		ether_d    = ether_q;
		hw_d       = hw_q;
		proto_d    = proto_q;
		src_addr_d = src_addr_q;
		dst_addr_d = dst_addr_q;
		sport_d    = sport_q;
		dport_d    = dport_q;

		if (counting && idx_q == IDX_W'(OFS_ETHERTYPE_HI))
			ether_d[15:8] = word.data_byte;
		if (counting && idx_q == IDX_W'(OFS_ETHERTYPE_LO))
			ether_d[7:0] = word.data_byte;
		if (counting && idx_q == IDX_W'(IP_BASE))
			hw_d = word.data_byte[3:0];
		if (counting && idx_q == IDX_W'(OFS_PROTOCOL))
			proto_d = word.data_byte;
		if (counting && idx_q >= IDX_W'(OFS_SRC_ADDR_FIRST) &&
				idx_q <= IDX_W'(OFS_SRC_ADDR_LAST))
			src_addr_d = {src_addr_q[23:0], word.data_byte};
		if (counting && idx_q >= IDX_W'(OFS_DST_ADDR_FIRST) &&
				idx_q <= IDX_W'(OFS_DST_ADDR_LAST))
			dst_addr_d = {dst_addr_q[23:0], word.data_byte};

		// The IHL taken from byte 14 already positions the ports for that byte.
		hw_bytes  = IDX_W'({hw_d, 2'b00});
		port_base = IDX_W'(IP_BASE) + hw_bytes;
		if (counting && idx_q >= port_base && idx_q <= port_base + IDX_W'(1))
			sport_d = {sport_q[7:0], word.data_byte};
		if (counting && idx_q >= port_base + IDX_W'(2) &&
				idx_q <= port_base + IDX_W'(3))
			dport_d = {dport_q[7:0], word.data_byte};

		ok = ether_d == ETHERTYPE_IPV4 && proto_d == PROTO_UDP &&
			idx_q >= LAST_MIN && idx_q >= NEED_BIAS + hw_bytes;
	end

	assign push = fire && word.last_byte;

	always_comb begin
		entry.accepted       = ok;
		entry.source_address = src_addr_d;
		entry.dest_address   = dst_addr_d;
		entry.source_port    = sport_d;
		entry.dest_udp       = dport_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			ether_q    <= '0;
			hw_q       <= '0;
			proto_q    <= '0;
			src_addr_q <= '0;
			dst_addr_q <= '0;
			sport_q    <= '0;
			dport_q    <= '0;
		end else if (fire) begin
			if (word.last_byte) begin
				idx_q      <= '0;
				ether_q    <= '0;
				hw_q       <= '0;
				proto_q    <= '0;
				src_addr_q <= '0;
				dst_addr_q <= '0;
				sport_q    <= '0;
				dport_q    <= '0;
			end else begin
				if (counting)
					idx_q <= idx_q + IDX_W'(1);
				ether_q    <= ether_d;
				hw_q       <= hw_d;
				proto_q    <= proto_d;
				src_addr_q <= src_addr_d;
				dst_addr_q <= dst_addr_d;
				sport_q    <= sport_d;
				dport_q    <= dport_d;
			end
		end
	end

endmodule

// ===== rtl/core/eiuh_fifo.sv =====
// Two-entry queue of classified frame results between front and back end.
// Depends on eiuh_pkg.
module eiuh_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  eiuh_pkg::out_word_t push_word,
	input  logic                pop,
	output eiuh_pkg::out_word_t head,
	output eiuh_pkg::q_status_t status
);
	import eiuh_pkg::*;

	out_word_t  mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign head             = mem_q[rd_ptr_q];
	assign status.full      = count_q == 2'd2;
	assign status.not_empty = count_q != 2'd0;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop)
				count_q <= count_q + 2'd1;
			else if (pop && !push)
				count_q <= count_q - 2'd1;
		end
	end

endmodule

// ===== rtl/core/eiuh_back.sv =====
// Back end: output register that formats and presents one result word.
// Depends on eiuh_pkg. Pulls from the result queue whenever the register frees up.
module eiuh_back (
	input  logic                clk,
	input  logic                arst_n,
	input  eiuh_pkg::q_status_t status,
	input  eiuh_pkg::out_word_t head,
	output logic                pop,
	input  logic                stall,
	output logic                valid,
	output eiuh_pkg::out_word_t word
);
	import eiuh_pkg::*;

	logic      valid_q;
	out_word_t word_q;

	assign pop   = status.not_empty && (!valid_q || !stall);
	assign valid = valid_q;
	assign word  = word_q;

	// A rejected frame reports zeros in every field.
	always_ff @(posedge clk) begin
		if (pop)
			word_q <= head.accepted ? head : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (!stall) begin
			valid_q <= 1'b0;
		end
	end

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for eth_ipv4_udp_header_extract: drives frames byte by byte
// and checks every result word against a built-in header predictor.
// Depends on eiuh_pkg and the RTL of the extractor.
`timescale 1ns / 1ps

class header_scoreboard;
	localparam int FRAME_LIMIT = eiuh_pkg::MAX_FRAME_BYTES_DEF;

	bit [13:0] frame_pos;
	bit [15:0] ether_type;
	bit [3:0]  ihl;
	bit [7:0]  proto;
	bit [31:0] src_ip;
	bit [31:0] dst_ip;
	bit [15:0] sport;
	bit [15:0] dport;

	eiuh_pkg::out_word_t expected_q[$];
	int errors;

	function new();
		clear_frame();
		errors = 0;
	endfunction

	function void clear_frame();
		frame_pos = '0;
		ether_type = '0;
		ihl = '0;
		proto = '0;
		src_ip = '0;
		dst_ip = '0;
		sport = '0;
		dport = '0;
	endfunction

	// Updates the header captures with one accepted input word and, on the last
	// byte of a frame, queues the result word the block must produce.
	function void note_byte(eiuh_pkg::in_word_t w);
		int unsigned idx;
		int unsigned port_base;
		int unsigned frame_len;
		int unsigned need;
		bit [7:0] b;
		eiuh_pkg::out_word_t r;
		idx = frame_pos;
		b = w.data_byte;
		if (idx < FRAME_LIMIT) begin
			if (idx == eiuh_pkg::OFS_ETHERTYPE_HI) ether_type[15:8] = b;
			if (idx == eiuh_pkg::OFS_ETHERTYPE_LO) ether_type[7:0] = b;
			if (idx == eiuh_pkg::IP_BASE) ihl = b[3:0];
			if (idx == eiuh_pkg::OFS_PROTOCOL) proto = b;
			if (idx >= eiuh_pkg::OFS_SRC_ADDR_FIRST && idx <= eiuh_pkg::OFS_SRC_ADDR_LAST)
				src_ip = {src_ip[23:0], b};
			if (idx >= eiuh_pkg::OFS_DST_ADDR_FIRST && idx <= eiuh_pkg::OFS_DST_ADDR_LAST)
				dst_ip = {dst_ip[23:0], b};
			// The header length captured from this very byte already moves the ports.
			port_base = eiuh_pkg::IP_BASE + eiuh_pkg::WORD_BYTES * ihl;
			if (idx >= port_base && idx <= port_base + 1)
				sport = {sport[7:0], b};
			if (idx >= port_base + 2 && idx <= port_base + 3)
				dport = {dport[7:0], b};
			frame_pos = idx + 1;
		end
		if (!w.last_byte)
			return;
		frame_len = idx + 1;
		need = eiuh_pkg::IP_BASE + eiuh_pkg::WORD_BYTES * ihl + eiuh_pkg::UDP_HDR_BYTES;
		r = '0;
		if (ether_type == eiuh_pkg::ETHERTYPE_IPV4 && proto == eiuh_pkg::PROTO_UDP &&
				frame_len >= eiuh_pkg::MIN_IP_END && frame_len >= need) begin
			r.accepted = 1'b1;
			r.source_address = src_ip;
			r.dest_address = dst_ip;
			r.source_port = sport;
			r.dest_udp = dport;
		end
		expected_q.push_back(r);
		clear_frame();
	endfunction

	function void check_result(eiuh_pkg::out_word_t act);
		eiuh_pkg::out_word_t e;
		if (expected_q.size() == 0) begin
			$display("%0t: result word with nothing expected, actual %h", $time, act);
			errors++;
			return;
		end
		e = expected_q.pop_front();
		if (act.accepted !== e.accepted) begin
			$display("%0t: accepted expected %0d actual %0d", $time, e.accepted, act.accepted);
			errors++;
		end
		if (act.source_address !== e.source_address) begin
			$display("%0t: source_address expected %h actual %h", $time,
				e.source_address, act.source_address);
			errors++;
		end
		if (act.dest_address !== e.dest_address) begin
			$display("%0t: dest_address expected %h actual %h", $time,
				e.dest_address, act.dest_address);
			errors++;
		end
		if (act.source_port !== e.source_port) begin
			$display("%0t: source_port expected %h actual %h", $time,
				e.source_port, act.source_port);
			errors++;
		end
		if (act.dest_udp !== e.dest_udp) begin
			$display("%0t: dest_udp expected %h actual %h", $time, e.dest_udp, act.dest_udp);
			errors++;
		end
	endfunction
endclass

module tb;
	logic                clk;
	logic                arst_n;
	logic                byte_valid;
	logic                byte_stall;
	eiuh_pkg::in_word_t  byte_word;
	logic                result_valid;
	logic                result_stall = 1'b0;
	eiuh_pkg::out_word_t result_word;

	header_scoreboard sb;
	int idle_pct;
	int stall_pct;
	int idle_tab[4] = '{0, 49, 0, 21};
	int stall_tab[4] = '{0, 0, 49, 21};

	eth_ipv4_udp_header_extract dut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.byte_word(byte_word),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_word(result_word)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		result_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			sb.check_result(result_word);
	end

	// Holds the word until the block takes it; valid stays high into the next call.
	task automatic send_byte(input eiuh_pkg::in_word_t w);
		while ($urandom_range(0, 99) < idle_pct) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_word <= w;
		do
			@(posedge clk);
		while (byte_stall);
		sb.note_byte(w);
	endtask

	task automatic send_frame(input bit [7:0] f[$]);
		eiuh_pkg::in_word_t w;
		for (int i = 0; i < f.size(); i++) begin
			w.data_byte = f[i];
			w.last_byte = (i == f.size() - 1);
			send_byte(w);
		end
	endtask

	// A negative fill gives random bytes; the header fields are then patched in.
	function automatic void build_frame(ref bit [7:0] f[$], input int len,
			input bit [15:0] etype, input bit [3:0] hlen, input bit [7:0] pr, input int fill);
		f.delete();
		for (int i = 0; i < len; i++)
			f.push_back(fill < 0 ? 8'($urandom_range(0, 255)) : 8'(fill));
		if (len > eiuh_pkg::OFS_ETHERTYPE_HI) f[eiuh_pkg::OFS_ETHERTYPE_HI] = etype[15:8];
		if (len > eiuh_pkg::OFS_ETHERTYPE_LO) f[eiuh_pkg::OFS_ETHERTYPE_LO] = etype[7:0];
		if (len > eiuh_pkg::IP_BASE) f[eiuh_pkg::IP_BASE][3:0] = hlen;
		if (len > eiuh_pkg::OFS_PROTOCOL) f[eiuh_pkg::OFS_PROTOCOL] = pr;
	endfunction

	task automatic send_random_frame(output int len);
		bit [7:0] f[$];
		int pick;
		int need;
		bit [3:0] hlen;
		bit [15:0] etype;
		bit [7:0] pr;
		pick = $urandom_range(0, 99);
		hlen = ($urandom_range(0, 99) < 60) ? 4'd5 : 4'($urandom_range(0, 15));
		need = eiuh_pkg::IP_BASE + eiuh_pkg::WORD_BYTES * hlen + eiuh_pkg::UDP_HDR_BYTES;
		if (need < eiuh_pkg::MIN_IP_END)
			need = eiuh_pkg::MIN_IP_END;
		etype = eiuh_pkg::ETHERTYPE_IPV4;
		pr = eiuh_pkg::PROTO_UDP;
		len = need + $urandom_range(0, 8);
		if (pick >= 85) begin
			// Noise: random bytes of any short length.
			len = $urandom_range(1, 48);
			etype = 16'($urandom_range(0, 65535));
			pr = 8'($urandom_range(0, 255));
		end else if (pick >= 70) begin
			case ($urandom_range(0, 2))
				0: len = $urandom_range(1, need - 1);
				1: etype = 16'($urandom_range(0, 65535));
				default: pr = 8'($urandom_range(0, 255));
			endcase
		end
		build_frame(f, len, etype, hlen, pr, -1);
		send_frame(f);
	endtask

	initial begin
		bit [7:0] f[$];
		int sent_bytes;
		int n;
		sb = new();
		idle_pct = 0;
		stall_pct = 0;
		arst_n <= 1'b0;
		byte_valid <= 1'b0;
		byte_word <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frames: lone last bytes, length boundaries, every small header
		// length, wrong ethertype and protocol, extreme byte values.
		f = '{8'h00};
		send_frame(f);
		f = '{8'hFF};
		send_frame(f);
		build_frame(f, 42, eiuh_pkg::ETHERTYPE_IPV4, 4'd5, eiuh_pkg::PROTO_UDP, -1);
		send_frame(f);
		build_frame(f, 41, eiuh_pkg::ETHERTYPE_IPV4, 4'd5, eiuh_pkg::PROTO_UDP, -1);
		send_frame(f);
		build_frame(f, 30, eiuh_pkg::ETHERTYPE_IPV4, 4'd5, eiuh_pkg::PROTO_UDP, -1);
		send_frame(f);
		for (int h = 0; h <= 4; h++) begin
			build_frame(f, 34, eiuh_pkg::ETHERTYPE_IPV4, 4'(h), eiuh_pkg::PROTO_UDP, -1);
			send_frame(f);
		end
		build_frame(f, 33, eiuh_pkg::ETHERTYPE_IPV4, 4'd0, eiuh_pkg::PROTO_UDP, -1);
		send_frame(f);
		build_frame(f, 82, eiuh_pkg::ETHERTYPE_IPV4, 4'd15, eiuh_pkg::PROTO_UDP, -1);
		send_frame(f);
		build_frame(f, 81, eiuh_pkg::ETHERTYPE_IPV4, 4'd15, eiuh_pkg::PROTO_UDP, -1);
		send_frame(f);
		build_frame(f, 42, 16'h0801, 4'd5, eiuh_pkg::PROTO_UDP, -1);
		send_frame(f);
		build_frame(f, 42, 16'h86DD, 4'd5, eiuh_pkg::PROTO_UDP, -1);
		send_frame(f);
		build_frame(f, 42, eiuh_pkg::ETHERTYPE_IPV4, 4'd5, 8'd6, -1);
		send_frame(f);
		build_frame(f, 42, eiuh_pkg::ETHERTYPE_IPV4, 4'd5, 8'd18, -1);
		send_frame(f);
		build_frame(f, 60, eiuh_pkg::ETHERTYPE_IPV4, 4'd5, eiuh_pkg::PROTO_UDP, 255);
		send_frame(f);
		build_frame(f, 60, eiuh_pkg::ETHERTYPE_IPV4, 4'd5, eiuh_pkg::PROTO_UDP, 0);
		send_frame(f);

		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = idle_tab[ph];
			stall_pct = stall_tab[ph];
			sent_bytes = 0;
			while (sent_bytes < 135) begin
				send_random_frame(n);
				sent_bytes += n;
			end
		end
		byte_valid <= 1'b0;

		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#2000000;
		$display("Simulation FAILED");
		$finish;
	end
endmodule
